@@ hdl/aes192_key_expansion_top_macros.svh @@
// assertion macros for the aes-192 key schedule block
// used by aes192_key_expansion_top; expects clk and rst in scope
`ifndef AES192_KEY_EXPANSION_TOP_MACROS_SVH
`define AES192_KEY_EXPANSION_TOP_MACROS_SVH

// condition in this cycle implies a consequence in the same cycle
`define AKE_ASSERT_NOW(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// condition in this cycle implies a consequence in the next cycle
`define AKE_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/aes192ke_pkg.sv @@
// shared types, constants and s-box for the aes-192 key schedule
// no dependencies
package aes192ke_pkg;

  localparam int unsigned KeyWords   = 6;
  localparam int unsigned SchedWords = 52;
  localparam int unsigned WordW      = 32;
  localparam int unsigned CntW       = $clog2(SchedWords);
  localparam int unsigned PhaseW     = $clog2(KeyWords);

  localparam logic [CntW-1:0]   LAST_WORD  = CntW'(SchedWords - 1);
  localparam logic [PhaseW-1:0] LAST_PHASE = PhaseW'(KeyWords - 1);
  localparam logic [7:0]        RCON_FIRST = 8'h01;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_t;

  typedef struct packed {
    logic [63:0] key_upper;
    logic [63:0] key_middle;
    logic [63:0] key_lower;
  } key_item_t;

  typedef struct packed {
    logic [3:0]  round_index;
    logic [63:0] round_key_upper;
    logic [63:0] round_key_lower;
    logic        last_key;
  } round_key_item_t;

  // control from the sequencer to the word unit
  typedef struct packed {
    logic       sub_en;
    logic [7:0] rcon;
  } word_ctrl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sbox_lookup(input logic [7:0] x);
    return SBOX[x];
  endfunction

endpackage

@@ hdl/aes192ke_word_unit.sv @@
// shared word unit: next schedule word from the oldest and newest window words
// depends on aes192ke_pkg
module aes192ke_word_unit (
  input  logic [31:0]              oldest,
  input  logic [31:0]              newest,
  input  aes192ke_pkg::word_ctrl_t ctrl,
  output logic [31:0]              next_word
);
  import aes192ke_pkg::*;

  logic [31:0] rot;
  logic [31:0] sub;
  logic [31:0] t;

  // rotword then subword on the newest word
  assign rot = {newest[23:0], newest[31:24]};
  assign sub = {sbox_lookup(rot[31:24]), sbox_lookup(rot[23:16]),
                sbox_lookup(rot[15:8]), sbox_lookup(rot[7:0])};

  // round constant folds into the top byte on every sixth word
  assign t = ctrl.sub_en ? (sub ^ {ctrl.rcon, 24'h000000}) : newest;

  assign next_word = oldest ^ t;

endmodule

@@ hdl/aes192_key_expansion_top.sv @@
// aes-192 key schedule: one 192-bit key in, thirteen 128-bit round keys out
// depends on aes192ke_pkg, aes192ke_word_unit, aes192_key_expansion_top_macros.svh
//
//  channel   dir  handshake               payload
//  key       in   key_valid / key_ready   key_item_t (three 64-bit key parts)
//  rkey      out  rkey_valid / rkey_ready round_key_item_t (index, 2x64 bits, last)
//
// one schedule word per cycle from the shared word unit while the output is not held:
// 52 steps per key, which is taken in the idle state; each round key is registered
// at the output once its four words are gathered
// key_ready is high only while idle; the next key may enter as the last
// round key still waits in the output register
// a held rkey freezes the sequencer whenever a new round key completes
// reset clears the sequencer state and the output valid
module aes192_key_expansion_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          key_valid,
  output logic                          key_ready,
  input  aes192ke_pkg::key_item_t       key,
  output logic                          rkey_valid,
  input  logic                          rkey_ready,
  output aes192ke_pkg::round_key_item_t rkey
);
  import aes192ke_pkg::*;

  seq_state_t        state;
  seq_state_t        state_next;
  logic [WordW-1:0]  win [KeyWords];
  logic [WordW-1:0]  acc [3];
  logic [CntW-1:0]   wcnt;
  logic [PhaseW-1:0] phase;
  logic [7:0]        rcon;
  logic              key_take;
  logic              can_push;
  logic              step;
  logic              push;
  word_ctrl_t        wctrl;
  logic [WordW-1:0]  new_word;

  // sequencer control
  always_comb begin
    key_take   = key_valid && key_ready;
    can_push   = !rkey_valid || rkey_ready;
    step       = 1'b0;
    push       = 1'b0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (key_valid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        step = (wcnt[1:0] != 2'd3) || can_push;
        push = step && (wcnt[1:0] == 2'd3);
        if (step && wcnt == LAST_WORD) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign key_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // shared word unit
  assign wctrl.sub_en = (phase == '0);
  assign wctrl.rcon   = rcon;

  aes192ke_word_unit u_word (
    .oldest    (win[0]),
    .newest    (win[KeyWords-1]),
    .ctrl      (wctrl),
    .next_word (new_word)
  );

  // six-word window: load the key, then shift the oldest word out each step
  always_ff @(posedge clk) begin
    if (key_take) begin
      win[0] <= key.key_upper[63:32];
      win[1] <= key.key_upper[31:0];
      win[2] <= key.key_middle[63:32];
      win[3] <= key.key_middle[31:0];
      win[4] <= key.key_lower[63:32];
      win[5] <= key.key_lower[31:0];
      wcnt   <= '0;
      phase  <= '0;
      rcon   <= RCON_FIRST;
    end else if (step) begin
      for (int k = 0; k < KeyWords - 1; k++) begin
        win[k] <= win[k+1];
      end
      win[KeyWords-1] <= new_word;
      wcnt            <= wcnt + 1'b1;
      phase           <= (phase == LAST_PHASE) ? '0 : phase + 1'b1;
      if (phase == '0) begin
        rcon <= {rcon[6:0], 1'b0};
      end
    end
  end

  // gather three words; the fourth goes straight into the output item
  always_ff @(posedge clk) begin
    if (step && wcnt[1:0] != 2'd3) begin
      acc[wcnt[1:0]] <= win[0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rkey_valid <= 1'b0;
    end else if (push) begin
      rkey_valid <= 1'b1;
    end else if (rkey_ready) begin
      rkey_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rkey.round_index     <= wcnt[CntW-1:2];
      rkey.round_key_upper <= {acc[0], acc[1]};
      rkey.round_key_lower <= {acc[2], win[0]};
      rkey.last_key        <= (wcnt == LAST_WORD);
    end
  end

`include "aes192_key_expansion_top_macros.svh"

  `AKE_ASSERT_NEXT(a_load_clears, key_take, state == ST_RUN && wcnt == '0 && phase == '0, "key load did not restart the schedule")
  `AKE_ASSERT_NEXT(a_stall_holds, state == ST_RUN && wcnt[1:0] == 2'd3 && rkey_valid && !rkey_ready, $stable(wcnt) && rkey_valid, "sequencer advanced over a held round key")
  `AKE_ASSERT_NOW(a_end_on_last, state == ST_RUN && state_next == ST_IDLE, push && wcnt == LAST_WORD, "schedule ended before the last round key")
  `AKE_ASSERT_NEXT(a_push_shows, push, rkey_valid && rkey.round_index == $past(wcnt[CntW-1:2]), "round key push not visible")

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// testbench for aes192_key_expansion_top: drives cipher keys, checks all 13 round keys
// depends on aes192ke_pkg and the rtl of aes192_key_expansion_top
module tb_top;
  import aes192ke_pkg::*;

  localparam int unsigned CLK_HALF      = 10;
  localparam int unsigned RESET_CYCLES  = 9;
  localparam int unsigned RKEYS_PER_KEY = 13;
  localparam int unsigned RAND_PER_MIX  = 120;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned DRAIN_CYCLES  = 64;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam logic [7:0]  GF_POLY       = 8'h1b;
  localparam logic [7:0]  AFFINE_CONST  = 8'h63;

  // scoreboard: expands each accepted key and checks round keys in order
  class round_key_board;
    round_key_item_t expected_q[$];
    logic [7:0]      sbox_tbl[256];
    int unsigned     mismatches;
    int unsigned     keys_seen;
    int unsigned     rkeys_checked;

    function logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      logic       hi;
      p = '0;
      for (int i = 0; i < 8; i++) begin
        if (b[0]) p ^= a;
        hi = a[7];
        a  = a << 1;
        if (hi) a ^= GF_POLY;
        b = b >> 1;
      end
      return p;
    endfunction

    // s-box from the field inverse (x^254) and the affine map
    function new();
      logic [7:0] inv;
      logic [7:0] x;
      mismatches    = 0;
      keys_seen     = 0;
      rkeys_checked = 0;
      for (int v = 0; v < 256; v++) begin
        x   = 8'(v);
        inv = 8'h01;
        for (int e = 0; e < 254; e++) inv = gf_mul(inv, x);
        sbox_tbl[v] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^
                      {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ AFFINE_CONST;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // run the 52-word schedule and queue the thirteen round keys
    function void note_key(input key_item_t k);
      logic [31:0]     w[52];
      logic [31:0]     t;
      logic [7:0]      rc;
      round_key_item_t rk;
      w[0] = k.key_upper[63:32];
      w[1] = k.key_upper[31:0];
      w[2] = k.key_middle[63:32];
      w[3] = k.key_middle[31:0];
      w[4] = k.key_lower[63:32];
      w[5] = k.key_lower[31:0];
      rc   = 8'h01;
      for (int i = 6; i < 52; i++) begin
        t = w[i-1];
        if (i % 6 == 0) begin
          t = {t[23:0], t[31:24]};
          t = {sbox_tbl[t[31:24]], sbox_tbl[t[23:16]], sbox_tbl[t[15:8]], sbox_tbl[t[7:0]]};
          t ^= {rc, 24'h0};
          rc = rc << 1;
        end
        w[i] = w[i-6] ^ t;
      end
      for (int r = 0; r < RKEYS_PER_KEY; r++) begin
        rk.round_index     = 4'(r);
        rk.round_key_upper = {w[4*r], w[4*r+1]};
        rk.round_key_lower = {w[4*r+2], w[4*r+3]};
        rk.last_key        = (r == RKEYS_PER_KEY - 1);
        expected_q.push_back(rk);
      end
      keys_seen++;
    endfunction

    function void check_rkey(input round_key_item_t got);
      round_key_item_t exp_rk;
      rkeys_checked++;
      if (expected_q.size() == 0) begin
        $error("round key with nothing expected: index %0d upper %h lower %h last %b",
               got.round_index, got.round_key_upper, got.round_key_lower, got.last_key);
        mismatches++;
        return;
      end
      exp_rk = expected_q.pop_front();
      if (got.round_index !== exp_rk.round_index) begin
        $error("round_index: expected %0d, actual %0d", exp_rk.round_index, got.round_index);
        mismatches++;
      end
      if (got.round_key_upper !== exp_rk.round_key_upper) begin
        $error("round_key_upper: expected %h, actual %h",
               exp_rk.round_key_upper, got.round_key_upper);
        mismatches++;
      end
      if (got.round_key_lower !== exp_rk.round_key_lower) begin
        $error("round_key_lower: expected %h, actual %h",
               exp_rk.round_key_lower, got.round_key_lower);
        mismatches++;
      end
      if (got.last_key !== exp_rk.last_key) begin
        $error("last_key: expected %b, actual %b", exp_rk.last_key, got.last_key);
        mismatches++;
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst;
  logic            key_valid;
  logic            key_ready;
  key_item_t       key;
  logic            rkey_valid;
  logic            rkey_ready;
  round_key_item_t rkey;

  round_key_board  sb = new();
  int unsigned     key_gap_pct;
  int unsigned     rkey_stall_pct;
  bit              hold_request;
  int unsigned     cycles;

  aes192_key_expansion_top uut (
    .clk        (clk),
    .rst        (rst),
    .key_valid  (key_valid),
    .key_ready  (key_ready),
    .key        (key),
    .rkey_valid (rkey_valid),
    .rkey_ready (rkey_ready),
    .rkey       (rkey)
  );

  always #(CLK_HALF) clk = ~clk;

  // offer one key, with a random gap first; valid stays up across back-to-back items
  task automatic send_key(input key_item_t k);
    while ($urandom_range(99) < key_gap_pct) begin
      key_valid <= 1'b0;
      @(posedge clk);
    end
    key_valid <= 1'b1;
    key       <= k;
    do @(posedge clk); while (!key_ready);
    sb.note_key(k);
  endtask

  function automatic logic [63:0] rand_field();
    case ($urandom_range(15))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_random_keys(input int unsigned n);
    key_item_t k;
    for (int i = 0; i < n; i++) begin
      k.key_upper  = rand_field();
      k.key_middle = rand_field();
      k.key_lower  = rand_field();
      send_key(k);
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    rkey_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        rkey_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      rkey_ready <= ($urandom_range(99) >= rkey_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && rkey_valid && rkey_ready) sb.check_rkey(rkey);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d round keys still expected", cycles, sb.pending());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    cycles         = 0;
    hold_request   = 1'b0;
    key_gap_pct    = 13;
    rkey_stall_pct = 59;
    rst       <= 1'b1;
    key_valid <= 1'b0;
    key       <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed keys: extremes, bit patterns and the standard example key
    send_key('{64'h0, 64'h0, 64'h0});
    send_key('{'1, '1, '1});
    send_key('{64'h8e73b0f7da0e6452, 64'hc810f32b809079e5, 64'h62f8ead2522c6b7b});
    send_key('{64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617});
    send_key('{64'h5555555555555555, 64'h5555555555555555, 64'h5555555555555555});
    send_key('{64'haaaaaaaaaaaaaaaa, 64'haaaaaaaaaaaaaaaa, 64'haaaaaaaaaaaaaaaa});
    send_key('{'1, 64'h0, 64'h0});
    send_key('{64'h0, '1, 64'h0});
    send_key('{64'h0, 64'h0, '1});
    send_key('{64'hffffffff00000000, 64'hffffffff00000000, 64'hffffffff00000000});
    send_key('{64'h00000000ffffffff, 64'h00000000ffffffff, 64'h00000000ffffffff});
    send_key('{64'h8000000000000001, 64'h8000000000000001, 64'h8000000000000001});

    // random keys under three idle mixes
    send_random_keys(RAND_PER_MIX);
    key_gap_pct    = 59;
    rkey_stall_pct = 13;
    send_random_keys(RAND_PER_MIX);
    key_gap_pct    = 0;
    rkey_stall_pct = 0;
    hold_request   = 1'b1;
    send_random_keys(RAND_PER_MIX);
    key_valid <= 1'b0;

    // drain
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("expanded %0d keys into %0d checked round keys", sb.keys_seen, sb.rkeys_checked);
    $display("idle mixes: sender-light, receiver-light, none with a long receiver hold-off");
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
